[sv/fcc_pkg.sv]
// Shared types, constants and the byte-wide CRC step for the frame CRC checker.
// No dependencies; every other file takes names from here by scope.
`timescale 1ns / 1ps
`default_nettype none

package fcc_pkg;

    // CRC-16/CCITT-FALSE
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    // Sync characters 'F' and 'L'
    localparam logic [7:0] SYNC_A = 8'h46;
    localparam logic [7:0] SYNC_B = 8'h4C;

    // Header byte offsets within a frame
    localparam int unsigned POS_SYNC_A  = 0;
    localparam int unsigned POS_SYNC_B  = 1;
    localparam int unsigned POS_VERSION = 2;
    localparam int unsigned POS_TYPE    = 3;
    localparam int unsigned POS_SEQ_LO  = 4;
    localparam int unsigned POS_SEQ_HI  = 5;
    localparam int unsigned POS_STATE   = 6;
    localparam int unsigned POS_TIME_0  = 7;
    localparam int unsigned POS_TIME_1  = 8;
    localparam int unsigned POS_TIME_2  = 9;
    localparam int unsigned POS_TIME_3  = 10;
    localparam int unsigned POS_TEXT    = 11;

    // Configuration register indexes
    localparam logic [1:0] CFG_EXPECTED_VERSION = 2'd0;
    localparam logic [1:0] CFG_TELEMETRY_TYPE   = 2'd1;
    localparam logic [1:0] CFG_STATUS_TYPE      = 2'd2;
    localparam logic [1:0] CFG_TEXT_LIMIT       = 2'd3;

    // Configuration reset values
    localparam logic [7:0] RST_EXPECTED_VERSION = 8'd1;
    localparam logic [7:0] RST_TELEMETRY_TYPE   = 8'd1;
    localparam logic [7:0] RST_STATUS_TYPE      = 8'd2;
    localparam logic [7:0] RST_TEXT_LIMIT       = 8'd34;

    // Result queue depth and pointer width
    localparam int unsigned QUEUE_DEPTH = 3;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 2;

    typedef enum logic [2:0] {
        ERR_OK          = 3'd0,
        ERR_SHORT       = 3'd1,
        ERR_BAD_SYNC    = 3'd2,
        ERR_BAD_VERSION = 3'd3,
        ERR_BAD_CRC     = 3'd4,
        ERR_TEXT_LONG   = 3'd5,
        ERR_UNKNOWN     = 3'd6
    } err_code_t;

    typedef struct packed {
        logic [7:0] expected_version;
        logic [7:0] telemetry_type_code;
        logic [7:0] status_type_code;
        logic [7:0] text_limit;
    } cfg_t;

    typedef struct packed {
        err_code_t   error_code;
        logic [15:0] sequence_res;
        logic [7:0]  frame_type;
        logic [7:0]  vehicle_state;
        logic [31:0] time_ms;
        logic [7:0]  text_length;
    } result_t;

    // Fold one byte into the running CRC, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[sv/frame_crc_checker.sv]
// Byte-serial frame checker with CRC-16/CCITT-FALSE. Takes one byte per clock while
// not stalled; a byte is registered on acceptance, checked against the frame state the
// next cycle, and a verdict lands in a three-entry result queue, so out_valid for a
// frame rises once the verdict on its last byte has been written into the queue.
// The input stalls only when the queue plus the byte in flight could fill it; with
// the output draining, the rate is one byte per cycle.
// Each frame gives one verdict; a new start on an open frame first gives a
// short-frame verdict. Depends on fcc_pkg, fcc_frame_track and fcc_result_queue.
`timescale 1ns / 1ps
`default_nettype none

module frame_crc_checker #(
    parameter int unsigned FRAME_BYTES = 48
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        frame_start,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       error_code,
    output logic [15:0]      sequence_res,
    output logic [7:0]       frame_type,
    output logic [7:0]       vehicle_state,
    output logic [31:0]      time_ms,
    output logic [7:0]       text_length
);

    fcc_pkg::cfg_t    cfg_reg;
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_start_reg;
    logic             push;
    fcc_pkg::result_t push_data;
    fcc_pkg::result_t head_data;
    logic [fcc_pkg::QCNT_W-1:0] q_count;
    logic [fcc_pkg::QCNT_W:0]   q_load;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_version    <= fcc_pkg::RST_EXPECTED_VERSION;
            cfg_reg.telemetry_type_code <= fcc_pkg::RST_TELEMETRY_TYPE;
            cfg_reg.status_type_code    <= fcc_pkg::RST_STATUS_TYPE;
            cfg_reg.text_limit          <= fcc_pkg::RST_TEXT_LIMIT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fcc_pkg::CFG_EXPECTED_VERSION: cfg_reg.expected_version    <= cfg_data;
                fcc_pkg::CFG_TELEMETRY_TYPE:   cfg_reg.telemetry_type_code <= cfg_data;
                fcc_pkg::CFG_STATUS_TYPE:      cfg_reg.status_type_code    <= cfg_data;
                fcc_pkg::CFG_TEXT_LIMIT:       cfg_reg.text_limit          <= cfg_data;
                default:                       cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Stall when the queue plus the byte in flight could fill it
    assign q_load   = {1'b0, q_count} + (fcc_pkg::QCNT_W + 1)'(in_valid_reg);
    assign in_stall = (q_load >= (fcc_pkg::QCNT_W + 1)'(fcc_pkg::QUEUE_DEPTH));

    // Register the accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid & ~in_stall;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg  <= rx_byte;
            in_start_reg <= frame_start;
        end
    end

    fcc_frame_track #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (in_valid_reg),
        .byte_in  (in_byte_reg),
        .start_in (in_start_reg),
        .cfg      (cfg_reg),
        .push     (push),
        .result   (push_data)
    );

    fcc_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop_stall  (out_stall),
        .head_valid (out_valid),
        .head_data  (head_data),
        .count      (q_count)
    );

    assign error_code    = head_data.error_code;
    assign sequence_res  = head_data.sequence_res;
    assign frame_type    = head_data.frame_type;
    assign vehicle_state = head_data.vehicle_state;
    assign time_ms       = head_data.time_ms;
    assign text_length   = head_data.text_length;

endmodule

`default_nettype wire

[sv/fcc_frame_track.sv]
// Frame tracker: byte position, running CRC, sync flag, header capture and verdict.
// Depends on fcc_pkg for the CRC step, the config struct and the result struct.
`timescale 1ns / 1ps
`default_nettype none

module fcc_frame_track #(
    parameter int unsigned FRAME_BYTES = 48
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire logic [7:0]           byte_in,
    input  wire logic                 start_in,
    input  wire fcc_pkg::cfg_t        cfg,
    output logic                      push,
    output fcc_pkg::result_t          result
);

    localparam int unsigned POS_W = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_TRAILER = POS_W'(FRAME_BYTES - 2);

    logic [POS_W-1:0] pos_reg,  pos_next;
    logic             open_reg, open_next;
    logic [15:0]      crc_reg,  crc_next;
    logic             sync_reg, sync_next;
    logic [7:0]       trailer_reg, trailer_next;
    logic [7:0]       version_reg, version_next;
    logic [7:0]       type_reg,    type_next;
    logic [15:0]      seq_reg,     seq_next;
    logic [7:0]       state_reg,   state_next;
    logic [31:0]      time_reg,    time_next;
    logic [7:0]       text_reg,    text_next;

    logic             open_eff;
    logic [POS_W-1:0] pos_eff;
    logic [15:0]      crc_eff;
    logic             sync_eff;
    logic             short_hit;
    logic             last_hit;
    logic [15:0]      rx_crc;
    logic             is_status;
    fcc_pkg::err_code_t code;

    // Track the frame and form the verdict
    always_comb
    begin
        open_eff = open_reg  | start_in;
        pos_eff  = start_in ? '0 : pos_reg;
        crc_eff  = start_in ? fcc_pkg::CRC_INIT : crc_reg;
        sync_eff = start_in | sync_reg;

        short_hit = fire & start_in & open_reg;
        last_hit  = fire & open_eff & (pos_eff == POS_LAST);

        pos_next     = pos_reg;
        open_next    = open_reg;
        crc_next     = crc_reg;
        sync_next    = sync_reg;
        trailer_next = trailer_reg;
        version_next = version_reg;
        type_next    = type_reg;
        seq_next     = seq_reg;
        state_next   = state_reg;
        time_next    = time_reg;
        text_next    = text_reg;

        if (fire && open_eff)
        begin
            open_next = 1'b1;
            crc_next  = crc_eff;
            sync_next = sync_eff;
            if (pos_eff < POS_TRAILER)
                crc_next = fcc_pkg::crc_byte(crc_eff, byte_in);
            if (pos_eff == POS_W'(fcc_pkg::POS_SYNC_A) && byte_in != fcc_pkg::SYNC_A)
                sync_next = 1'b0;
            if (pos_eff == POS_W'(fcc_pkg::POS_SYNC_B) && byte_in != fcc_pkg::SYNC_B)
                sync_next = 1'b0;

            // Capture header bytes
            if (pos_eff == POS_W'(fcc_pkg::POS_VERSION)) version_next = byte_in;
            if (pos_eff == POS_W'(fcc_pkg::POS_TYPE))    type_next    = byte_in;
            if (pos_eff == POS_W'(fcc_pkg::POS_SEQ_LO))  seq_next[7:0]   = byte_in;
            if (pos_eff == POS_W'(fcc_pkg::POS_SEQ_HI))  seq_next[15:8]  = byte_in;
            if (pos_eff == POS_W'(fcc_pkg::POS_STATE))   state_next   = byte_in;
            if (pos_eff == POS_W'(fcc_pkg::POS_TIME_0))  time_next[7:0]   = byte_in;
            if (pos_eff == POS_W'(fcc_pkg::POS_TIME_1))  time_next[15:8]  = byte_in;
            if (pos_eff == POS_W'(fcc_pkg::POS_TIME_2))  time_next[23:16] = byte_in;
            if (pos_eff == POS_W'(fcc_pkg::POS_TIME_3))  time_next[31:24] = byte_in;
            if (pos_eff == POS_W'(fcc_pkg::POS_TEXT))    text_next    = byte_in;
            if (pos_eff == POS_TRAILER)                  trailer_next = byte_in;

            if (pos_eff == POS_LAST)
            begin
                open_next = 1'b0;
                pos_next  = '0;
            end
            else
            begin
                pos_next = pos_eff + POS_W'(1);
            end
        end

        // Verdict, checks in priority order
        rx_crc    = {byte_in, trailer_reg};
        is_status = 1'b0;
        if (!sync_reg)
            code = fcc_pkg::ERR_BAD_SYNC;
        else if (version_reg != cfg.expected_version)
            code = fcc_pkg::ERR_BAD_VERSION;
        else if (rx_crc != crc_reg)
            code = fcc_pkg::ERR_BAD_CRC;
        else if (type_reg == cfg.status_type_code)
        begin
            is_status = 1'b1;
            code = (text_reg > cfg.text_limit) ? fcc_pkg::ERR_TEXT_LONG : fcc_pkg::ERR_OK;
        end
        else if (type_reg != cfg.telemetry_type_code)
            code = fcc_pkg::ERR_UNKNOWN;
        else
            code = fcc_pkg::ERR_OK;

        // Build the result; header fields only on ok or late errors
        push   = short_hit | last_hit;
        result = '0;
        if (short_hit)
        begin
            result.error_code = fcc_pkg::ERR_SHORT;
        end
        else
        begin
            result.error_code = code;
            if (code == fcc_pkg::ERR_OK || code == fcc_pkg::ERR_TEXT_LONG ||
                code == fcc_pkg::ERR_UNKNOWN)
            begin
                result.sequence_res  = seq_reg;
                result.frame_type    = type_reg;
                result.vehicle_state = state_reg;
                result.time_ms       = time_reg;
                if (is_status)
                    result.text_length = text_reg;
            end
        end
    end

    // Hold frame control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            open_reg <= 1'b0;
            crc_reg  <= fcc_pkg::CRC_INIT;
            sync_reg <= 1'b1;
        end
        else
        begin
            pos_reg  <= pos_next;
            open_reg <= open_next;
            crc_reg  <= crc_next;
            sync_reg <= sync_next;
        end
    end

    // Header and trailer capture; every byte is written before the verdict reads it
    always_ff @(posedge clk)
    begin
        trailer_reg <= trailer_next;
        version_reg <= version_next;
        type_reg    <= type_next;
        seq_reg     <= seq_next;
        state_reg   <= state_next;
        time_reg    <= time_next;
        text_reg    <= text_next;
    end

endmodule

`default_nettype wire

[sv/fcc_result_queue.sv]
// Small result queue between the frame tracker and the output channel.
// Depends on fcc_pkg for the result struct and queue sizing.
`timescale 1ns / 1ps
`default_nettype none

module fcc_result_queue (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    input  wire fcc_pkg::result_t                  push_data,
    input  wire logic                              pop_stall,
    output logic                                   head_valid,
    output fcc_pkg::result_t                       head_data,
    output logic [fcc_pkg::QCNT_W-1:0]             count
);

    localparam logic [fcc_pkg::QPTR_W-1:0] PTR_LAST = fcc_pkg::QPTR_W'(fcc_pkg::QUEUE_DEPTH - 1);

    fcc_pkg::result_t mem_reg [fcc_pkg::QUEUE_DEPTH];

    logic [fcc_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [fcc_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [fcc_pkg::QCNT_W-1:0] count_reg,  count_next;
    logic                       pop;

    // Advance pointers and occupancy
    always_comb
    begin
        pop         = (count_reg != '0) & ~pop_stall;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + fcc_pkg::QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + fcc_pkg::QPTR_W'(1);
        count_next = count_reg + fcc_pkg::QCNT_W'(push) - fcc_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store an incoming result
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

`default_nettype wire

[test/frame_crc_checker_test.sv]
// Self-checking bench for frame_crc_checker: random and directed byte streams,
// predicted verdicts compared against the output channel. Depends on fcc_pkg and
// frame_crc_checker.
`timescale 1ns / 1ps

module frame_crc_checker_test;

    localparam int FRAME_BYTES   = 48;
    localparam int PHASE_ITEMS   = 140;
    localparam int PHASES        = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        logic [7:0] data;
        logic       start;
    } link_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = fcc_pkg::CFG_EXPECTED_VERSION;
    logic [7:0]  cfg_data = 8'h00;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        frame_start = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  error_code;
    logic [15:0] sequence_res;
    logic [7:0]  frame_type;
    logic [7:0]  vehicle_state;
    logic [31:0] time_ms;
    logic [7:0]  text_length;

    // Requests waiting to be offered, and verdicts waiting to arrive
    link_byte_t pending_bytes[$];
    link_byte_t offered;
    bit         offer_busy = 1'b0;
    fcc_pkg::result_t verdict_q[$];
    fcc_pkg::result_t want;
    int         queued_count = 0;
    int         fault_count = 0;
    int         cycle_count = 0;

    // Idling knobs per phase
    int gap_pct = 0;
    int stall_pct = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;

    // Register copies as the block should hold them
    logic [7:0] want_version = fcc_pkg::RST_EXPECTED_VERSION;
    logic [7:0] want_telem   = fcc_pkg::RST_TELEMETRY_TYPE;
    logic [7:0] want_status  = fcc_pkg::RST_STATUS_TYPE;
    logic [7:0] want_limit   = fcc_pkg::RST_TEXT_LIMIT;

    // Frame tracker state
    logic [7:0]  trk_pos = 8'd0;
    bit          trk_open = 1'b0;
    logic [15:0] trk_crc = fcc_pkg::CRC_INIT;
    bit          trk_sync_ok = 1'b1;
    logic [7:0]  trk_trail = 8'h00;
    logic [7:0]  trk_hdr [12];

    frame_crc_checker #(
        .FRAME_BYTES(FRAME_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .frame_start(frame_start),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .error_code(error_code),
        .sequence_res(sequence_res),
        .frame_type(frame_type),
        .vehicle_state(vehicle_state),
        .time_ms(time_ms),
        .text_length(text_length)
    );

    always #2 clk = ~clk;

    // CRC-16/CCITT-FALSE, one data bit at a time
    function automatic logic [15:0] fold_crc(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0} ^ (fb ? fcc_pkg::CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // Advance the frame tracker by one accepted request, queue any verdict
    task automatic track_byte(input logic [7:0] b, input logic st);
        fcc_pkg::result_t   r;
        fcc_pkg::err_code_t code;
        logic [15:0] rx_crc;
        bit          is_status;
        if (st) begin
            if (trk_open) begin
                r = '0;
                r.error_code = fcc_pkg::ERR_SHORT;
                verdict_q.push_back(r);
            end
            trk_open = 1'b1;
            trk_pos = 8'd0;
            trk_crc = fcc_pkg::CRC_INIT;
            trk_sync_ok = 1'b1;
            trk_trail = 8'h00;
            trk_hdr = '{default: 8'h00};
        end
        if (!trk_open)
            return;

        if (trk_pos < FRAME_BYTES - 2)
            trk_crc = fold_crc(trk_crc, b);
        if (trk_pos == fcc_pkg::POS_SYNC_A && b != fcc_pkg::SYNC_A)
            trk_sync_ok = 1'b0;
        if (trk_pos == fcc_pkg::POS_SYNC_B && b != fcc_pkg::SYNC_B)
            trk_sync_ok = 1'b0;
        if (trk_pos >= fcc_pkg::POS_VERSION && trk_pos <= fcc_pkg::POS_TEXT)
            trk_hdr[trk_pos] = b;
        if (trk_pos == FRAME_BYTES - 2)
            trk_trail = b;

        if (trk_pos != FRAME_BYTES - 1) begin
            trk_pos = trk_pos + 8'd1;
            return;
        end

        // Last byte: checks in order sync, version, crc, type
        rx_crc = {b, trk_trail};
        code = fcc_pkg::ERR_OK;
        is_status = 1'b0;
        if (!trk_sync_ok)
            code = fcc_pkg::ERR_BAD_SYNC;
        else if (trk_hdr[fcc_pkg::POS_VERSION] != want_version)
            code = fcc_pkg::ERR_BAD_VERSION;
        else if (rx_crc != trk_crc)
            code = fcc_pkg::ERR_BAD_CRC;
        else if (trk_hdr[fcc_pkg::POS_TYPE] == want_status) begin
            is_status = 1'b1;
            if (trk_hdr[fcc_pkg::POS_TEXT] > want_limit)
                code = fcc_pkg::ERR_TEXT_LONG;
        end else if (trk_hdr[fcc_pkg::POS_TYPE] != want_telem)
            code = fcc_pkg::ERR_UNKNOWN;

        r = '0;
        r.error_code = code;
        if (code == fcc_pkg::ERR_OK || code == fcc_pkg::ERR_TEXT_LONG ||
            code == fcc_pkg::ERR_UNKNOWN) begin
            r.sequence_res  = {trk_hdr[fcc_pkg::POS_SEQ_HI], trk_hdr[fcc_pkg::POS_SEQ_LO]};
            r.frame_type    = trk_hdr[fcc_pkg::POS_TYPE];
            r.vehicle_state = trk_hdr[fcc_pkg::POS_STATE];
            r.time_ms       = {trk_hdr[fcc_pkg::POS_TIME_3], trk_hdr[fcc_pkg::POS_TIME_2],
                               trk_hdr[fcc_pkg::POS_TIME_1], trk_hdr[fcc_pkg::POS_TIME_0]};
            if (is_status)
                r.text_length = trk_hdr[fcc_pkg::POS_TEXT];
        end
        verdict_q.push_back(r);
        trk_open = 1'b0;
        trk_pos = 8'd0;
    endtask

    function automatic void check_field(input string field, input logic [31:0] expv,
                                        input logic [31:0] got);
        if (got !== expv) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, expv, got);
            fault_count++;
        end
    endfunction

    // Drive the next request at the falling edge; hold it until taken
    always @(negedge clk) begin
        if (!offer_busy) begin
            if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
                offered = pending_bytes.pop_front();
                rx_byte <= offered.data;
                frame_start <= offered.start;
                in_valid <= 1'b1;
                offer_busy = 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Stall the output at random, or for a long hold when asked
    always @(negedge clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Sample both handshakes at the rising edge
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("frame_crc_checker_test: FAIL");
            $finish;
        end else begin
            if (rst_n && in_valid && !in_stall) begin
                track_byte(offered.data, offered.start);
                offer_busy = 1'b0;
            end
            if (rst_n && out_valid && !out_stall) begin
                if (verdict_q.size() == 0) begin
                    $error("verdict with none expected: error_code %0d", error_code);
                    fault_count++;
                end else begin
                    want = verdict_q.pop_front();
                    check_field("error_code", want.error_code, error_code);
                    check_field("sequence_res", want.sequence_res, sequence_res);
                    check_field("frame_type", want.frame_type, frame_type);
                    check_field("vehicle_state", want.vehicle_state, vehicle_state);
                    check_field("time_ms", want.time_ms, time_ms);
                    check_field("text_length", want.text_length, text_length);
                end
            end
        end
    end

    task automatic push_byte(input logic [7:0] d, input logic st);
        link_byte_t item;
        item.data = d;
        item.start = st;
        pending_bytes.push_back(item);
        queued_count++;
    endtask

    // Build a frame with a correct trailer xor crc_mask; send its first cut bytes
    task automatic push_frame(input logic [7:0] sa, input logic [7:0] sb,
                              input logic [7:0] ver, input logic [7:0] typ,
                              input logic [15:0] seq, input logic [7:0] vstate,
                              input logic [31:0] tms, input logic [7:0] txt,
                              input logic [15:0] crc_mask, input int cut);
        logic [7:0]  frm [FRAME_BYTES];
        logic [15:0] crc;
        frm[fcc_pkg::POS_SYNC_A]  = sa;
        frm[fcc_pkg::POS_SYNC_B]  = sb;
        frm[fcc_pkg::POS_VERSION] = ver;
        frm[fcc_pkg::POS_TYPE]    = typ;
        frm[fcc_pkg::POS_SEQ_LO]  = seq[7:0];
        frm[fcc_pkg::POS_SEQ_HI]  = seq[15:8];
        frm[fcc_pkg::POS_STATE]   = vstate;
        frm[fcc_pkg::POS_TIME_0]  = tms[7:0];
        frm[fcc_pkg::POS_TIME_1]  = tms[15:8];
        frm[fcc_pkg::POS_TIME_2]  = tms[23:16];
        frm[fcc_pkg::POS_TIME_3]  = tms[31:24];
        frm[fcc_pkg::POS_TEXT]    = txt;
        for (int k = fcc_pkg::POS_TEXT + 1; k < FRAME_BYTES - 2; k++)
            frm[k] = 8'($urandom_range(0, 255));
        crc = fcc_pkg::CRC_INIT;
        for (int k = 0; k < FRAME_BYTES - 2; k++)
            crc = fold_crc(crc, frm[k]);
        crc = crc ^ crc_mask;
        frm[FRAME_BYTES - 2] = crc[7:0];
        frm[FRAME_BYTES - 1] = crc[15:8];
        for (int k = 0; k < cut; k++)
            push_byte(frm[k], k == 0);
    endtask

    // Write one register while the block is idle
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            fcc_pkg::CFG_EXPECTED_VERSION: want_version = val;
            fcc_pkg::CFG_TELEMETRY_TYPE:   want_telem = val;
            fcc_pkg::CFG_STATUS_TYPE:      want_status = val;
            fcc_pkg::CFG_TEXT_LIMIT:       want_limit = val;
            default: ;
        endcase
    endtask

    // Wait until every request is taken and every verdict is in
    task automatic drain();
        while (pending_bytes.size() != 0 || offer_busy || verdict_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial begin
        int         phase_start;
        int         pick;
        int         n;
        int         cut;
        logic [7:0] sa;
        logic [7:0] sb;
        logic [7:0] ver;
        logic [7:0] typ;
        logic [7:0] txt;
        logic [15:0] mask;
        logic [7:0] cfg_plan [PHASES][4];
        int         gap_plan [4];
        int         stall_plan [4];

        cfg_plan = '{'{8'd1, 8'd1, 8'd2, 8'd34},
                     '{8'd0, 8'd0, 8'd0, 8'd0},
                     '{8'd255, 8'd255, 8'd255, 8'd255},
                     '{8'd17, 8'd7, 8'd9, 8'd128},
                     '{8'd1, 8'd1, 8'd2, 8'd34},
                     '{8'd200, 8'd2, 8'd1, 8'd255},
                     '{8'd3, 8'd3, 8'd4, 8'd1},
                     '{8'd0, 8'd255, 8'd0, 8'd0}};
        gap_plan = '{0, 47, 0, 19};
        stall_plan = '{0, 0, 47, 19};
        trk_hdr = '{default: 8'h00};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed frames under reset configuration
        pending_bytes.push_back('{data: 8'h00, start: 1'b0});
        pending_bytes.push_back('{data: 8'hFF, start: 1'b0});
        pending_bytes.push_back('{data: fcc_pkg::SYNC_A, start: 1'b0});
        push_frame(fcc_pkg::SYNC_A, fcc_pkg::SYNC_B, 8'd1, 8'd1, 16'hFFFF, 8'hFF,
                   32'hFFFF_FFFF, 8'hFF, 16'h0000, FRAME_BYTES);
        push_frame(fcc_pkg::SYNC_A, fcc_pkg::SYNC_B, 8'd1, 8'd2, 16'h0000, 8'h00,
                   32'h0, 8'd34, 16'h0000, FRAME_BYTES);
        push_frame(fcc_pkg::SYNC_A, fcc_pkg::SYNC_B, 8'd1, 8'd2, 16'h1234, 8'h55,
                   32'hA5A5_5A5A, 8'd35, 16'h0000, FRAME_BYTES);
        push_frame(8'h00, fcc_pkg::SYNC_B, 8'd0, 8'd9, 16'h0001, 8'h01, 32'h1, 8'd0,
                   16'hFFFF, FRAME_BYTES);
        push_frame(fcc_pkg::SYNC_A, 8'hFF, 8'd1, 8'd1, 16'h8000, 8'h80, 32'h8000_0000,
                   8'd0, 16'h0000, FRAME_BYTES);
        push_frame(fcc_pkg::SYNC_A, fcc_pkg::SYNC_B, 8'd0, 8'd1, 16'h00FF, 8'h7F,
                   32'h7FFF_FFFF, 8'd0, 16'h0001, FRAME_BYTES);
        push_frame(fcc_pkg::SYNC_A, fcc_pkg::SYNC_B, 8'd1, 8'd1, 16'hFF00, 8'h01,
                   32'h0000_FFFF, 8'd0, 16'h8001, FRAME_BYTES);
        push_frame(fcc_pkg::SYNC_A, fcc_pkg::SYNC_B, 8'd1, 8'd255, 16'hBEEF, 8'h42,
                   32'hDEAD_BEEF, 8'd200, 16'h0000, FRAME_BYTES);
        push_frame(fcc_pkg::SYNC_A, fcc_pkg::SYNC_B, 8'd1, 8'd1, 16'h1111, 8'h11,
                   32'h1111_1111, 8'd0, 16'h0000, 20);
        push_frame(fcc_pkg::SYNC_A, fcc_pkg::SYNC_B, 8'd1, 8'd1, 16'h2222, 8'h22,
                   32'h2222_2222, 8'd0, 16'h0000, FRAME_BYTES - 1);
        push_frame(fcc_pkg::SYNC_A, fcc_pkg::SYNC_B, 8'd1, 8'd2, 16'h3333, 8'h33,
                   32'h3333_3333, 8'd0, 16'h0000, FRAME_BYTES);
        pending_bytes.push_back('{data: fcc_pkg::SYNC_A, start: 1'b0});
        pending_bytes.push_back('{data: 8'h00, start: 1'b0});
        drain();

        for (int p = 0; p < PHASES; p++) begin
            // Reconfigure while idle
            write_reg(fcc_pkg::CFG_EXPECTED_VERSION, cfg_plan[p][0]);
            write_reg(fcc_pkg::CFG_TELEMETRY_TYPE, cfg_plan[p][1]);
            write_reg(fcc_pkg::CFG_STATUS_TYPE, cfg_plan[p][2]);
            write_reg(fcc_pkg::CFG_TEXT_LIMIT, cfg_plan[p][3]);
            @(negedge clk);
            cfg_write <= 1'b0;
            gap_pct = gap_plan[p % 4];
            stall_pct = stall_plan[p % 4];

            // Back-to-back starts behind a long output hold fill the result queue
            if (p == 0) begin
                hold_req = 1'b1;
                for (int k = 0; k < 40; k++)
                    push_byte(8'($urandom_range(0, 255)), 1'b1);
            end

            phase_start = queued_count;
            while (queued_count - phase_start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 84) begin
                    sa = ($urandom_range(0, 99) < 5) ? 8'($urandom_range(0, 255))
                                                     : fcc_pkg::SYNC_A;
                    sb = ($urandom_range(0, 99) < 5) ? 8'($urandom_range(0, 255))
                                                     : fcc_pkg::SYNC_B;
                    ver = ($urandom_range(0, 99) < 6) ? 8'($urandom_range(0, 255))
                                                      : want_version;
                    n = $urandom_range(0, 99);
                    typ = (n < 40) ? want_telem :
                          (n < 80) ? want_status : 8'($urandom_range(0, 255));
                    txt = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, want_limit))
                                                      : 8'($urandom_range(0, 255));
                    mask = ($urandom_range(0, 99) < 8) ? 16'($urandom_range(1, 65535))
                                                       : 16'h0000;
                    cut = (pick < 72) ? FRAME_BYTES : $urandom_range(1, FRAME_BYTES - 1);
                    push_frame(sa, sb, ver, typ, 16'($urandom_range(0, 65535)),
                               8'($urandom_range(0, 255)), $urandom(), txt, mask, cut);
                end else if (pick < 92) begin
                    // Stray bytes with no start; ignored unless a frame is open
                    n = $urandom_range(1, 6);
                    for (int k = 0; k < n; k++)
                        pending_bytes.push_back('{data: 8'($urandom_range(0, 255)),
                                                  start: 1'b0});
                end else begin
                    n = $urandom_range(1, 24);
                    for (int k = 0; k < n; k++)
                        push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
                end
            end
            drain();
        end

        if (verdict_q.size() != 0) begin
            $error("%0d verdicts never arrived", verdict_q.size());
            fault_count++;
        end
        if (fault_count == 0)
            $display("frame_crc_checker_test: PASS");
        else
            $display("frame_crc_checker_test: FAIL");
        $finish;
    end

endmodule
